[rtl/core/nig_pkg.sv]
// shared constants, command and status types for the nonce index replay guard
package nig_pkg;

  localparam int unsigned INDEX_COUNT = 1024;
  localparam int unsigned SLOT_COUNT  = 64;
  localparam int unsigned IDX_W       = $clog2(INDEX_COUNT);
  localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT);
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned CNT_W       = $clog2(TICK_W);
  localparam int unsigned EXP_W       = 6;
  localparam int unsigned NIDX_W      = 11;

  localparam logic [EXP_W-1:0] EXPIRE_RESET = EXP_W'(30);

  // action codes
  localparam logic ACT_RESERVE = 1'b0;
  localparam logic ACT_CHECK   = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic load;
    logic div_step;
    logic stamp_init;
    logic stamp_step;
    logic mark_rd;
    logic res_decide;
    logic chk_rd;
    logic chk_decide;
    logic out_load;
  } nig_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic div_last;
    logic stamp_done;
  } nig_stat_t;

endpackage

[rtl/core/nig_if.sv]
// request, response and configuration channel interfaces
interface nig_req_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [nig_pkg::TICK_W-1:0]      tick_seconds;
  logic [nig_pkg::NIDX_W-1:0]      nonce_index;
  modport source (output valid, action, tick_seconds, nonce_index, input ready);
  modport sink   (input valid, action, tick_seconds, nonce_index, output ready);
endinterface

interface nig_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [nig_pkg::IDX_W-1:0]       granted_index;
  modport source (output valid, ok, granted_index, input ready);
  modport sink   (input valid, ok, granted_index, output ready);
endinterface

interface nig_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [nig_pkg::EXP_W-1:0]       expire_seconds;
  modport source (output valid, expire_seconds, input ready);
  modport sink   (input valid, expire_seconds, output ready);
endinterface

[rtl/core/nig_ctrl.sv]
// sequencing state machine for the replay guard
module nig_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nig_pkg::nig_cmd_t cmd_o,
  input  nig_pkg::nig_stat_t st_i
);
  import nig_pkg::*;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_SETUP   = 4'd3;
  localparam logic [3:0] S_STAMP   = 4'd4;
  localparam logic [3:0] S_MARK    = 4'd5;
  localparam logic [3:0] S_RES_DEC = 4'd6;
  localparam logic [3:0] S_CHK_RD  = 4'd7;
  localparam logic [3:0] S_CHK_DEC = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (st_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (in_action_i == ACT_RESERVE) ? S_DIV : S_CHK_RD;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) state_d = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.stamp_init = 1'b1;
        state_d = S_STAMP;
      end
      S_STAMP: begin
        if (st_i.stamp_done) state_d = S_MARK;
        else cmd_o.stamp_step = 1'b1;
      end
      S_MARK: begin
        cmd_o.mark_rd = 1'b1;
        state_d = S_RES_DEC;
      end
      S_RES_DEC: begin
        cmd_o.res_decide = 1'b1;
        state_d = S_DONE;
      end
      S_CHK_RD: begin
        cmd_o.chk_rd = 1'b1;
        state_d = S_CHK_DEC;
      end
      S_CHK_DEC: begin
        cmd_o.chk_decide = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/nig_dp.sv]
// datapath: tick modulo unit, slot marks, used bits, ring pointer and result
module nig_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [nig_pkg::TICK_W-1:0]   tick_i,
  input  logic [nig_pkg::NIDX_W-1:0]   nidx_i,
  input  logic                         cfg_we_i,
  input  logic [nig_pkg::EXP_W-1:0]    cfg_data_i,
  input  nig_pkg::nig_cmd_t            cmd_i,
  output nig_pkg::nig_stat_t           st_o,
  output logic                         ok_o,
  output logic [nig_pkg::IDX_W-1:0]    gidx_o
);
  import nig_pkg::*;

  // configuration register
  logic [EXP_W-1:0] expire_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) expire_q <= EXPIRE_RESET;
    else if (cfg_we_i) expire_q <= cfg_data_i;
  end

  logic [EXP_W:0] mod_m;
  assign mod_m = {1'b0, expire_q} + (EXP_W+1)'(1);

  // clearing pass counter
  logic [IDX_W:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clear_step && !clr_q[IDX_W]) clr_q <= clr_q + (IDX_W+1)'(1);
  end

  // item registers
  logic [TICK_W-1:0] tick_q;
  logic [NIDX_W-1:0] nidx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tick_q <= tick_i;
      nidx_q <= nidx_i;
    end
  end

  // restoring modulo, one tick bit per cycle
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] rem_q;
  logic [SLOT_W:0]   rem_sh;
  assign rem_sh = {rem_q, tick_q[cnt_q]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cnt_q <= CNT_W'(TICK_W-1);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (rem_sh >= mod_m) rem_q <= SLOT_W'(rem_sh - mod_m);
      else rem_q <= rem_sh[SLOT_W-1:0];
    end
  end

  // ring pointer and slot state
  logic              started_q;
  logic [IDX_W:0]    nf_q;
  logic [SLOT_W-1:0] last_q;
  logic [SLOT_W:0]   ptr_q;

  // stamp value: empty when the ring pointer is zero
  logic              stamp_live;
  logic [IDX_W-1:0]  stamp_val;
  assign stamp_live = (nf_q != '0);
  assign stamp_val  = nf_q[IDX_W] ? {IDX_W{1'b1}} : IDX_W'(nf_q - (IDX_W+1)'(1));

  // slot mark memory with valid bits
  logic [IDX_W:0]        mark_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] mark_vld_q;
  logic [IDX_W:0]        mark_rd_q;
  logic                  mark_vrd_q;
  logic [SLOT_W-1:0]     mark_addr;
  logic                  stamp_we;

  assign stamp_we  = cmd_i.stamp_step && (ptr_q < mod_m);
  assign mark_addr = cmd_i.mark_rd ? rem_q : last_q;

  always_ff @(posedge clk_i) begin
    if (stamp_we) mark_mem[ptr_q[SLOT_W-1:0]] <= {stamp_live, stamp_val};
    if (cmd_i.mark_rd || cmd_i.chk_rd) begin
      mark_rd_q  <= mark_mem[mark_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_vld_q <= '0;
      mark_vrd_q <= 1'b0;
    end else begin
      if (stamp_we) mark_vld_q[ptr_q[SLOT_W-1:0]] <= 1'b1;
      if (cmd_i.mark_rd || cmd_i.chk_rd) mark_vrd_q <= mark_vld_q[mark_addr];
    end
  end

  logic             mk_empty;
  logic [IDX_W-1:0] mk;
  assign mk_empty = !mark_vrd_q || !mark_rd_q[IDX_W];
  assign mk       = mark_rd_q[IDX_W-1:0];

  // stamp walk, divide and clearing status
  assign st_o.stamp_done = (ptr_q == {1'b0, rem_q});
  assign st_o.div_last   = (cnt_q == '0);
  assign st_o.clear_done = clr_q[IDX_W];

  // reserve decision
  logic             nf_full;
  logic             nf_gt;
  logic             res_grant;
  logic [IDX_W-1:0] res_idx;
  assign nf_full = nf_q[IDX_W];
  assign nf_gt   = nf_q > {1'b0, mk};
  assign res_idx = nf_full ? '0 : nf_q[IDX_W-1:0];
  always_comb begin
    if (mk_empty) res_grant = !nf_full;
    else if (nf_gt) res_grant = !(nf_full && mk == '0);
    else res_grant = (nf_q != {1'b0, mk});
  end

  // check decision
  logic used_rd_q;
  logic in_win;
  logic chk_ok;
  always_comb begin
    if (nf_q < {1'b0, mk}) in_win = ({1'b0, nidx_q[IDX_W-1:0]} >= {1'b0, mk}) ||
                                    ({1'b0, nidx_q[IDX_W-1:0]} <= nf_q);
    else in_win = ({1'b0, nidx_q[IDX_W-1:0]} >= {1'b0, mk}) &&
                  ({1'b0, nidx_q[IDX_W-1:0]} <= nf_q);
    if (!started_q || nidx_q[IDX_W]) chk_ok = 1'b0;
    else if (mk_empty) chk_ok = ({1'b0, nidx_q[IDX_W-1:0]} < nf_q);
    else chk_ok = in_win && !used_rd_q;
  end

  // used bit memory, one write port
  logic             used_mem [INDEX_COUNT];
  logic             used_we;
  logic [IDX_W-1:0] used_wa;
  logic             used_wd;
  always_comb begin
    used_we = 1'b0;
    used_wa = clr_q[IDX_W-1:0];
    used_wd = 1'b0;
    if (cmd_i.clear_step && !clr_q[IDX_W]) begin
      used_we = 1'b1;
    end else if (cmd_i.res_decide) begin
      used_we = res_grant;
      used_wa = res_idx;
    end else if (cmd_i.chk_decide) begin
      used_we = chk_ok;
      used_wa = nidx_q[IDX_W-1:0];
      used_wd = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    if (cmd_i.chk_rd) used_rd_q <= used_mem[nidx_q[IDX_W-1:0]];
  end

  // ring pointer, last slot and stamp walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      nf_q      <= '0;
      last_q    <= '0;
      ptr_q     <= '0;
    end else begin
      if (cmd_i.stamp_init) begin
        if (!started_q) begin
          started_q <= 1'b1;
          nf_q      <= '0;
          ptr_q     <= {1'b0, rem_q};
        end else begin
          ptr_q     <= {1'b0, last_q};
        end
      end
      if (cmd_i.stamp_step) begin
        if (ptr_q >= mod_m) ptr_q <= '0;
        else ptr_q <= ptr_q + (SLOT_W+1)'(1);
      end
      if (cmd_i.mark_rd) last_q <= rem_q;
      if (cmd_i.res_decide) begin
        if (res_grant) nf_q <= {1'b0, res_idx} + (IDX_W+1)'(1);
        else if (!mk_empty && nf_full) nf_q <= '0;
      end
    end
  end

  // working result and output register
  logic             rok_q;
  logic [IDX_W-1:0] ridx_q;
  logic             ok_q;
  logic [IDX_W-1:0] gidx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_decide) begin
      rok_q  <= res_grant;
      ridx_q <= res_grant ? res_idx : '0;
    end
    if (cmd_i.chk_decide) begin
      rok_q  <= chk_ok;
      ridx_q <= '0;
    end
    if (cmd_i.out_load) begin
      ok_q   <= rok_q;
      gidx_q <= ridx_q;
    end
  end

  assign ok_o   = ok_q;
  assign gidx_o = gidx_q;

endmodule

[rtl/core/nonce_index_replay_guard_unit.sv]
// top level of the nonce index replay guard
// reserve: the bit-serial tick modulo, then the stamp walk of one slot per cycle,
//   then the slot mark read and the reserve decision produce the result
// check: a mark and used bit read, then the check decision; one request in work at a time
// after reset a clearing pass over the used bits runs before requests are taken
// the result register lets the next request in while a result waits
module nonce_index_replay_guard_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  nig_req_if.sink        req_i,
  nig_rsp_if.source      rsp_o,
  nig_cfg_if.sink        cfg_i
);
  import nig_pkg::*;

  nig_cmd_t  cmd;
  nig_stat_t st;

  // configuration always taken
  assign cfg_i.ready = 1'b1;

  nig_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  nig_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (req_i.tick_seconds),
    .nidx_i     (req_i.nonce_index),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.expire_seconds),
    .cmd_i      (cmd),
    .st_o       (st),
    .ok_o       (rsp_o.ok),
    .gidx_o     (rsp_o.granted_index)
  );

endmodule
